FILE: rtl/scatter_point_alpha_rasterizer_core_assert.svh
// Assertion macros used by the back end (spar_back) of the rasterizer core RTL.
`ifndef SCATTER_POINT_ALPHA_RASTERIZER_CORE_ASSERT_SVH
`define SCATTER_POINT_ALPHA_RASTERIZER_CORE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SPAR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/spar_pkg.sv
// ----------------------------------------------------------------------------
// spar_pkg
// Shared types, constants and helper functions of the scatter point rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package spar_pkg;

    localparam int GRID_W_DEF = 256;
    localparam int GRID_H_DEF = 256;
    localparam int JOB_ADDR_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [2:0] CFG_X_SCALE = 3'd1;
    localparam logic [2:0] CFG_Y_ORIGIN = 3'd2;
    localparam logic [2:0] CFG_Y_SCALE = 3'd3;
    localparam logic [2:0] CFG_COLOR = 3'd4;
    localparam logic [2:0] CFG_WIDTH = 3'd5;
    localparam logic [2:0] CFG_HEIGHT = 3'd6;

    localparam logic [15:0] T_ONE = 16'hFFFF;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] weight;
        logic [15:0] transmit;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic is_read;
        logic clr;
        logic oob;
        logic [JOB_ADDR_W-1:0] addr;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/spar_ram.sv
// ----------------------------------------------------------------------------
// spar_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spar_front.sv
// ----------------------------------------------------------------------------
// spar_front
// Accepts items, maps plot points to pixels and classifies them into jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module spar_front #(
    parameter int GRID_W = spar_pkg::GRID_W_DEF,
    parameter int GRID_H = spar_pkg::GRID_H_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic               action,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic [7:0]         pixel_col,
    input  wire logic [7:0]         pixel_row,
    input  wire logic               clear_after,
    input  wire logic signed [31:0] x_origin,
    input  wire logic signed [31:0] x_scale,
    input  wire logic signed [31:0] y_origin,
    input  wire logic signed [31:0] y_scale,
    input  wire logic [8:0]         width_in_use,
    input  wire logic [8:0]         height_in_use,
    output logic                    busy,
    output logic                    push,
    output spar_pkg::job_t          job
);
    import spar_pkg::*;

    localparam int CW = $clog2(GRID_W);
    localparam int RW = $clog2(GRID_H);
    localparam int LW = 13;

    logic               v1_reg, v2_reg;
    logic               rd1_reg, rd2_reg;
    logic               clr1_reg, clr2_reg;
    logic [7:0]         col1_reg, col2_reg, row1_reg, row2_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [64:0] px_reg, py_reg;
    logic [LW-1:0]      wlim, hlim;
    logic [31:0]        idx_x, idx_y;
    logic               keep;
    logic               oob;
    logic [JOB_ADDR_W-1:0] plot_addr, read_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd1_reg <= action;
            clr1_reg <= clear_after;
            col1_reg <= pixel_col;
            row1_reg <= pixel_row;
            dx_reg <= 33'(point_x) - 33'(x_origin);
            dy_reg <= 33'(point_y) - 33'(y_origin);
        end
        rd2_reg <= rd1_reg;
        clr2_reg <= clr1_reg;
        col2_reg <= col1_reg;
        row2_reg <= row1_reg;
        px_reg <= 65'(dx_reg) * 65'(x_scale);
        py_reg <= 65'(dy_reg) * 65'(y_scale);
    end

    assign wlim = ({4'd0, width_in_use} > LW'(GRID_W)) ? LW'(GRID_W) : {4'd0, width_in_use};
    assign hlim = ({4'd0, height_in_use} > LW'(GRID_H)) ? LW'(GRID_H) : {4'd0, height_in_use};
    assign idx_x = px_reg[63:32];
    assign idx_y = py_reg[63:32];
    assign keep = !px_reg[64] && (idx_x < {19'd0, wlim})
               && !py_reg[64] && (idx_y < {19'd0, hlim});
    assign plot_addr = JOB_ADDR_W'(idx_y[RW-1:0]) * JOB_ADDR_W'(GRID_W)
                     + JOB_ADDR_W'(idx_x[CW-1:0]);
    assign oob = ({5'd0, col2_reg} >= LW'(GRID_W)) || ({5'd0, row2_reg} >= LW'(GRID_H));
    assign read_addr = JOB_ADDR_W'(row2_reg) * JOB_ADDR_W'(GRID_W) + JOB_ADDR_W'(col2_reg);

    assign busy = v1_reg || v2_reg;
    assign push = v2_reg && (rd2_reg || keep);
    assign job.is_read = rd2_reg;
    assign job.clr = clr2_reg;
    assign job.oob = rd2_reg && oob;
    assign job.addr = rd2_reg ? read_addr : plot_addr;

endmodule

`default_nettype wire

FILE: rtl/spar_queue.sv
// ----------------------------------------------------------------------------
// spar_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spar_queue #(
    parameter int DEPTH = spar_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire spar_pkg::job_t push_job,
    input  wire logic           pop,
    output spar_pkg::job_t      head,
    output logic                empty,
    output logic                full
);
    import spar_pkg::*;

    localparam int PW = $clog2(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

    assign head = slot_reg[rp_reg];
    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == (PW+1)'(DEPTH));

endmodule

`default_nettype wire

FILE: rtl/spar_back.sv
// ----------------------------------------------------------------------------
// spar_back
// Carries out jobs on the pixel memory: accumulation, reads with division
// and clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scatter_point_alpha_rasterizer_core_assert.svh"

module spar_back #(
    parameter int GRID_W = spar_pkg::GRID_W_DEF,
    parameter int GRID_H = spar_pkg::GRID_H_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire spar_pkg::job_t head,
    input  wire logic           empty,
    output logic                pop,
    output logic                clearing,
    input  wire logic [31:0]    color_rgba,
    output logic                result_valid,
    input  wire logic           result_stall,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic [15:0]         out_alpha,
    output logic                visible
);
    import spar_pkg::*;

    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_DATA = 3'd2;
    localparam logic [2:0] B_P1 = 3'd3;
    localparam logic [2:0] B_P2 = 3'd4;
    localparam logic [2:0] B_DIV = 3'd5;
    localparam logic [2:0] B_OUT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   clr_cnt_reg;
    job_t          job_reg;
    cell_t         cell_reg, rdata, wdata;
    logic          we, load;
    logic [AW-1:0] waddr;
    logic [23:0]   tprod_reg;
    logic [17:0]   q0_reg;
    logic [25:0]   chk;
    logic [31:0]   rem_reg [3];
    logic [7:0]    quo_reg [3];
    logic          sat_reg [3];
    logic [2:0]    bit_reg;
    logic [39:0]   dv;
    logic [7:0]    a;
    logic          res_valid_reg;
    cell_t         clear_cell;

    assign a = color_rgba[7:0];
    assign clear_cell = '{red: '0, green: '0, blue: '0, weight: '0, transmit: T_ONE};

    spar_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk),
        .we(we),
        .waddr(waddr),
        .wdata(wdata),
        .re(pop),
        .raddr(head.addr[AW-1:0]),
        .rdata(rdata)
    );

    assign pop = (state_reg == B_IDLE) && !empty;
    assign clearing = (state_reg == B_CLEAR);
    assign load = (state_reg == B_OUT) && (!res_valid_reg || !result_stall);
    assign chk = 26'(q0_reg) * 26'd255;
    assign dv = {8'd0, cell_reg.weight} << bit_reg;

    always_comb
    begin
        we = 1'b0;
        waddr = job_reg.addr[AW-1:0];
        wdata = clear_cell;
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_cnt_reg[AW-1:0];
                if (clr_cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = head.oob ? B_OUT : B_DATA;
                end
            end
            B_DATA:
            begin
                if (!job_reg.is_read)
                begin
                    state_next = B_P1;
                end
                else if (rdata.weight == '0)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_P1:
            begin
                state_next = B_P2;
            end
            B_P2:
            begin
                we = 1'b1;
                wdata = cell_reg;
                wdata.transmit = (chk > 26'(tprod_reg)) ? 16'(q0_reg - 1'b1) : q0_reg[15:0];
                state_next = B_IDLE;
            end
            B_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (load)
                begin
                    we = job_reg.clr && !job_reg.oob;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_cnt_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (state_reg == B_DATA)
        begin
            cell_reg <= rdata;
            bit_reg <= 3'd7;
            if (!job_reg.is_read)
            begin
                cell_reg.red <= sat_add32(rdata.red, 32'(color_rgba[31:24] * a));
                cell_reg.green <= sat_add32(rdata.green, 32'(color_rgba[23:16] * a));
                cell_reg.blue <= sat_add32(rdata.blue, 32'(color_rgba[15:8] * a));
                cell_reg.weight <= sat_add32(rdata.weight, 32'(a));
                tprod_reg <= 24'(rdata.transmit) * 24'(8'd255 - a);
            end
            rem_reg[0] <= rdata.red;
            rem_reg[1] <= rdata.green;
            rem_reg[2] <= rdata.blue;
            sat_reg[0] <= {8'd0, rdata.red} >= {rdata.weight, 8'd0};
            sat_reg[1] <= {8'd0, rdata.green} >= {rdata.weight, 8'd0};
            sat_reg[2] <= {8'd0, rdata.blue} >= {rdata.weight, 8'd0};
            for (int i = 0; i < 3; i++)
            begin
                quo_reg[i] <= '0;
            end
        end
        if (state_reg == B_P1)
        begin
            q0_reg <= 18'((41'(tprod_reg) * 41'd32897) >> 23);
        end
        if (state_reg == B_DIV)
        begin
            bit_reg <= bit_reg - 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                if ({8'd0, rem_reg[i]} >= dv)
                begin
                    rem_reg[i] <= rem_reg[i] - dv[31:0];
                    quo_reg[i][bit_reg] <= 1'b1;
                end
            end
        end
        if (load)
        begin
            visible <= !job_reg.oob && (cell_reg.weight != '0);
            if (job_reg.oob || (cell_reg.weight == '0))
            begin
                out_red <= '0;
                out_green <= '0;
                out_blue <= '0;
                out_alpha <= '0;
            end
            else
            begin
                out_red <= sat_reg[0] ? 8'hFF : quo_reg[0];
                out_green <= sat_reg[1] ? 8'hFF : quo_reg[1];
                out_blue <= sat_reg[2] ? 8'hFF : quo_reg[2];
                out_alpha <= T_ONE - cell_reg.transmit;
            end
        end
    end

    assign result_valid = res_valid_reg;

    `SPAR_ASSERT_IMP(a_pop_nonempty, pop, !empty)
    `SPAR_ASSERT_IMP(a_load_in_out, load, state_reg == B_OUT)
    `SPAR_ASSERT_NEXT(a_write_back_idle, state_reg == B_P2, state_reg == B_IDLE)
    `SPAR_ASSERT_IMP(a_clear_no_pop, clearing, !pop && !load)

endmodule

`default_nettype wire

FILE: rtl/scatter_point_alpha_rasterizer_core.sv
// ----------------------------------------------------------------------------
// scatter_point_alpha_rasterizer_core
// Maps plot points to pixels, alpha-blends them into a pixel memory and
// answers pixel reads with weighted mean colors and combined opacity.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    action .. clear_after
//  result    out        result_valid / result_stall out_red .. visible
//  config    in         cfg_write                  cfg_index, cfg_data
//
// The front takes no new item while its two mapping stages hold the last one. A plot
// item goes through the back states IDLE, DATA, P1 and P2. A read item goes through
// IDLE, DATA, DIV with the 8-step shared quotient unit, and OUT, skipping DIV when the
// weight is zero and DATA too off the grid. Items go through the pixel memory one at
// a time. After reset a clearing pass over all GRID_W*GRID_H cells runs before the
// first item is accepted. A stalled result stops the back only when the next read is
// ready to give its result, and the items behind that read wait in the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scatter_point_alpha_rasterizer_core #(
    parameter int GRID_W = spar_pkg::GRID_W_DEF,
    parameter int GRID_H = spar_pkg::GRID_H_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               action,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic [7:0]         pixel_col,
    input  wire logic [7:0]         pixel_row,
    input  wire logic               clear_after,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [7:0]              out_red,
    output logic [7:0]              out_green,
    output logic [7:0]              out_blue,
    output logic [15:0]             out_alpha,
    output logic                    visible,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import spar_pkg::*;

    logic signed [31:0] x_origin_reg, x_scale_reg, y_origin_reg, y_scale_reg;
    logic [31:0]        color_reg;
    logic [8:0]         width_reg, height_reg;
    logic               accept, front_busy, push, pop, q_empty, q_full, clearing;
    job_t               push_job, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            x_scale_reg <= 32'sd65536;
            y_origin_reg <= '0;
            y_scale_reg <= -32'sd65536;
            color_reg <= 32'hFFFF_FFFF;
            width_reg <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_X_ORIGIN: x_origin_reg <= cfg_data;
                CFG_X_SCALE: x_scale_reg <= cfg_data;
                CFG_Y_ORIGIN: y_origin_reg <= cfg_data;
                CFG_Y_SCALE: y_scale_reg <= cfg_data;
                CFG_COLOR: color_reg <= cfg_data;
                CFG_WIDTH: width_reg <= cfg_data[8:0];
                CFG_HEIGHT: height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign item_stall = front_busy || q_full || clearing;
    assign accept = item_valid && !item_stall;

    spar_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .action(action),
        .point_x(point_x),
        .point_y(point_y),
        .pixel_col(pixel_col),
        .pixel_row(pixel_row),
        .clear_after(clear_after),
        .x_origin(x_origin_reg),
        .x_scale(x_scale_reg),
        .y_origin(y_origin_reg),
        .y_scale(y_scale_reg),
        .width_in_use(width_reg),
        .height_in_use(height_reg),
        .busy(front_busy),
        .push(push),
        .job(push_job)
    );

    spar_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_job(push_job),
        .pop(pop),
        .head(head),
        .empty(q_empty),
        .full(q_full)
    );

    spar_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .empty(q_empty),
        .pop(pop),
        .clearing(clearing),
        .color_rgba(color_reg),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .out_alpha(out_alpha),
        .visible(visible)
    );

endmodule

`default_nettype wire
